// File: rtl/core/scv_pkg.sv
// ----------------------------------------------------------------------------
// scv_pkg
// Shared widths, constants and register codes of the smootherstep curve
// evaluator.
// ----------------------------------------------------------------------------
package scv_pkg;

  // default parameter values
  localparam int MAX_ANCHORS_DEF = 16;
  localparam int COORD_BITS_DEF  = 32;

  // datapath widths
  localparam int T_W   = 31;  // local fraction and its powers, Q1.30
  localparam int W_W   = 40;  // signed blend weight, Q9.30
  localparam int M_W   = 63;  // magnitude, capped at 2^62
  localparam int OUT_W = 48;  // result components, Q32.16

  localparam logic [T_W-1:0] ONE_Q30 = T_W'(1) << 30;
  localparam logic [M_W-1:0] MAG_CAP = M_W'(1) << 62;

  // polynomial coefficients of smootherstep and its derivatives
  localparam int C_6   = 6;
  localparam int C_10  = 10;
  localparam int C_15  = 15;
  localparam int C_30  = 30;
  localparam int C_60  = 60;
  localparam int C_120 = 120;
  localparam int C_180 = 180;
  localparam int C_360 = 360;

  // derivative orders
  localparam logic [1:0] ORD_POS   = 2'd0;
  localparam logic [1:0] ORD_FIRST = 2'd1;
  localparam logic [1:0] ORD_SECOND = 2'd2;
  localparam logic [1:0] ORD_THIRD = 2'd3;

  // item modes
  localparam logic MODE_WRITE = 1'b0;
  localparam logic MODE_EVAL  = 1'b1;

  // configuration registers
  localparam int ADDR_W = 4;
  localparam logic [1:0] REG_Q_START      = 2'd0;
  localparam logic [1:0] REG_Q_SCALE      = 2'd1;
  localparam logic [1:0] REG_ANCHOR_COUNT = 2'd2;

  localparam logic [31:0] Q_SCALE_RST      = 32'd983040;
  localparam logic [4:0]  ANCHOR_COUNT_RST = 5'd16;

endpackage

// File: rtl/core/scv_anchor_mem.sv
// ----------------------------------------------------------------------------
// scv_anchor_mem
// Anchor table: one write port, two registered read ports.
// ----------------------------------------------------------------------------
module scv_anchor_mem #(
  parameter int DEPTH  = scv_pkg::MAX_ANCHORS_DEF,
  parameter int WORD_W = 3 * scv_pkg::COORD_BITS_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WORD_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WORD_W-1:0]        rdata_a,
  output logic [WORD_W-1:0]        rdata_b
);

  logic [WORD_W-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read ports, held while the pipeline stalls
  always_ff @(posedge clk) begin
    if (en) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

// File: rtl/core/scv_weight.sv
// ----------------------------------------------------------------------------
// scv_weight
// Powers of the local fraction and the smootherstep weight for the
// requested derivative order, five register stages.
// ----------------------------------------------------------------------------
module scv_weight (
  input  logic                          clk,
  input  logic                          en,
  input  logic [scv_pkg::T_W-1:0]       t,
  input  logic [1:0]                    ord,
  output logic signed [scv_pkg::W_W-1:0] w
);

  localparam int TW = scv_pkg::T_W;
  localparam int WW = scv_pkg::W_W;

  logic [TW-1:0] t1_5, t2_5;
  logic [TW-1:0] t1_6, t2_6, t3_6;
  logic [TW-1:0] t1_7, t2_7, t3_7, t4_7;
  logic [TW-1:0] t1_8, t2_8, t3_8, t4_8, t5_8;
  logic [1:0]    ord_5, ord_6, ord_7, ord_8;
  logic [2*TW-1:0] sq_prod, p3_prod, p4_prod, p5_prod;
  logic signed [WW-1:0] w_next;
  logic signed [WW-1:0] s1, s2, s3, s4, s5, one;

  assign sq_prod = t * t;
  assign p3_prod = t2_5 * t1_5;
  assign p4_prod = t3_6 * t1_6;
  assign p5_prod = t4_7 * t1_7;

  // power chain, one multiply per stage
  always_ff @(posedge clk) begin
    if (en) begin
      t1_5  <= t;
      t2_5  <= TW'(sq_prod >> 30);
      ord_5 <= ord;
      t1_6  <= t1_5;
      t2_6  <= t2_5;
      t3_6  <= TW'(p3_prod >> 30);
      ord_6 <= ord_5;
      t1_7  <= t1_6;
      t2_7  <= t2_6;
      t3_7  <= t3_6;
      t4_7  <= TW'(p4_prod >> 30);
      ord_7 <= ord_6;
      t1_8  <= t1_7;
      t2_8  <= t2_7;
      t3_8  <= t3_7;
      t4_8  <= t4_7;
      t5_8  <= TW'(p5_prod >> 30);
      ord_8 <= ord_7;
    end
  end

  // polynomial for the selected order
  always_comb begin
    s1  = $signed(WW'(t1_8));
    s2  = $signed(WW'(t2_8));
    s3  = $signed(WW'(t3_8));
    s4  = $signed(WW'(t4_8));
    s5  = $signed(WW'(t5_8));
    one = $signed(WW'(scv_pkg::ONE_Q30));
    case (ord_8)
      scv_pkg::ORD_POS:
        w_next = WW'(scv_pkg::C_6) * s5 - WW'(scv_pkg::C_15) * s4
               + WW'(scv_pkg::C_10) * s3;
      scv_pkg::ORD_FIRST:
        w_next = WW'(scv_pkg::C_30) * s4 - WW'(scv_pkg::C_60) * s3
               + WW'(scv_pkg::C_30) * s2;
      scv_pkg::ORD_SECOND:
        w_next = WW'(scv_pkg::C_120) * s3 - WW'(scv_pkg::C_180) * s2
               + WW'(scv_pkg::C_60) * s1;
      default:
        w_next = WW'(scv_pkg::C_360) * s2 - WW'(scv_pkg::C_360) * s1
               + WW'(scv_pkg::C_60) * one;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      w <= w_next;
    end
  end

endmodule

// File: rtl/core/scv_lane.sv
// ----------------------------------------------------------------------------
// scv_lane
// One coordinate lane: anchor difference times weight, repeated scaling
// by q_scale per derivative order, sign, offset and 48-bit clipping.
// ----------------------------------------------------------------------------
module scv_lane #(
  parameter int COORD_BITS = scv_pkg::COORD_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            en,
  input  logic signed [COORD_BITS-1:0]    a0,
  input  logic signed [COORD_BITS-1:0]    a1,
  input  logic [1:0]                      ord,
  input  logic signed [scv_pkg::W_W-1:0]  w,
  input  logic [31:0]                     q_scale,
  output logic signed [scv_pkg::OUT_W-1:0] res,
  output logic                            sat
);

  localparam int CB   = COORD_BITS;
  localparam int DW   = CB + 1;
  localparam int WW   = scv_pkg::W_W;
  localparam int HW   = WW / 2;
  localparam int PW   = DW + WW - HW;
  localparam int SW   = DW + WW;
  localparam int MW   = scv_pkg::M_W;
  localparam int RW   = MW + 3;
  localparam logic signed [RW-1:0] OUT_MAX = RW'((66'sd1 <<< 47) - 66'sd1);
  localparam logic signed [RW-1:0] OUT_MIN = -RW'(66'sd1 <<< 47);

  // difference and its delay line up to the weight
  logic signed [DW-1:0] d_dly [4];
  logic signed [CB-1:0] a0_dly [4];
  logic [1:0]           ord_dly [4];

  always_ff @(posedge clk) begin
    if (en) begin
      d_dly[0]   <= DW'(a1) - DW'(a0);
      a0_dly[0]  <= a0;
      ord_dly[0] <= ord;
      for (int i = 1; i < 4; i++) begin
        d_dly[i]   <= d_dly[i-1];
        a0_dly[i]  <= a0_dly[i-1];
        ord_dly[i] <= ord_dly[i-1];
      end
    end
  end

  // magnitudes and result sign
  logic [DW-1:0]        md;
  logic [WW-1:0]        mw;
  logic                 neg_10;
  logic signed [CB-1:0] a0_10;
  logic [1:0]           ord_10;

  always_ff @(posedge clk) begin
    if (en) begin
      md     <= d_dly[3][DW-1] ? DW'(-d_dly[3]) : DW'(d_dly[3]);
      mw     <= w[WW-1] ? WW'(-w) : WW'(w);
      neg_10 <= d_dly[3][DW-1] ^ w[WW-1];
      a0_10  <= a0_dly[3];
      ord_10 <= ord_dly[3];
    end
  end

  // weight product as two partial products
  logic [PW-1:0]        plo, phi;
  logic                 neg_11;
  logic signed [CB-1:0] a0_11;
  logic [1:0]           ord_11;

  always_ff @(posedge clk) begin
    if (en) begin
      plo    <= PW'(md * mw[HW-1:0]);
      phi    <= PW'(md * mw[WW-1:HW]);
      neg_11 <= neg_10;
      a0_11  <= a0_10;
      ord_11 <= ord_10;
    end
  end

  // per-step stage registers, index 0 is the weighted magnitude
  logic [MW-1:0]        m_s   [4];
  logic                 neg_s [4];
  logic signed [CB-1:0] a0_s  [4];
  logic [1:0]           ord_s [4];
  logic [SW-1:0]        wsum;

  assign wsum = (SW'(phi) << HW) + SW'(plo);

  always_ff @(posedge clk) begin
    if (en) begin
      m_s[0]   <= MW'(wsum >> 30);
      neg_s[0] <= neg_11;
      a0_s[0]  <= a0_11;
      ord_s[0] <= ord_11;
    end
  end

  // one q_scale multiply per derivative order, two stages each
  for (genvar k = 0; k < 3; k++) begin : g_scale
    logic [63:0]          lo;
    logic [62:0]          hi;
    logic [MW-1:0]        m_a;
    logic                 neg_a;
    logic signed [CB-1:0] a0_a;
    logic [1:0]           ord_a;
    logic [95:0]          prod;
    logic [79:0]          shifted;
    logic [MW-1:0]        m_next;

    always_ff @(posedge clk) begin
      if (en) begin
        lo    <= m_s[k][31:0] * q_scale;
        hi    <= 63'(m_s[k][62:32] * q_scale);
        m_a   <= m_s[k];
        neg_a <= neg_s[k];
        a0_a  <= a0_s[k];
        ord_a <= ord_s[k];
      end
    end

    assign prod    = {hi, 32'd0} + 96'(lo);
    assign shifted = prod[95:16];

    always_comb begin
      if (ord_a > 2'(k)) begin
        if (shifted > 80'(scv_pkg::MAG_CAP)) begin
          m_next = scv_pkg::MAG_CAP;
        end else begin
          m_next = shifted[MW-1:0];
        end
      end else begin
        m_next = m_a;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        m_s[k+1]   <= m_next;
        neg_s[k+1] <= neg_a;
        a0_s[k+1]  <= a0_a;
        ord_s[k+1] <= ord_a;
      end
    end
  end

  // sign, anchor offset for position, clipping
  logic signed [RW-1:0] mag, r_sum;

  always_comb begin
    mag = $signed(RW'(m_s[3]));
    r_sum = neg_s[3] ? -mag : mag;
    if (ord_s[3] == scv_pkg::ORD_POS) begin
      r_sum = r_sum + RW'(a0_s[3]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (r_sum > OUT_MAX) begin
        res <= OUT_MAX[scv_pkg::OUT_W-1:0];
        sat <= 1'b1;
      end else if (r_sum < OUT_MIN) begin
        res <= OUT_MIN[scv_pkg::OUT_W-1:0];
        sat <= 1'b1;
      end else begin
        res <= r_sum[scv_pkg::OUT_W-1:0];
        sat <= 1'b0;
      end
    end
  end

endmodule

// File: rtl/core/smootherstep_curve_evaluator.sv
// ----------------------------------------------------------------------------
// smootherstep_curve_evaluator
// Piecewise quintic smootherstep curve through a table of 3D anchors.
// ----------------------------------------------------------------------------
// Accepts one item per clock unless a result waits at the output; write
// items take the same path as evaluates and return nothing. The path
// holds the multiply chain: position scaling, the four powers of the
// fraction, the weight product and three q_scale multiplies. The anchor
// table is read and written at the same pipeline stage, so an evaluate
// sees every write transferred before it.
// The whole pipeline stalls only while a result waits at the output.
// Registers (APB, byte address 4*i): q_start, q_scale, anchor_count.
// ----------------------------------------------------------------------------
module smootherstep_curve_evaluator #(
  parameter int MAX_ANCHORS = scv_pkg::MAX_ANCHORS_DEF,
  parameter int COORD_BITS  = scv_pkg::COORD_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // configuration port
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [scv_pkg::ADDR_W-1:0]   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  // input items
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic                         mode,
  input  logic [1:0]                   deriv_order,
  input  logic signed [31:0]           sample_position,
  input  logic [3:0]                   anchor_slot,
  input  logic signed [31:0]           anchor_x,
  input  logic signed [31:0]           anchor_y,
  input  logic signed [31:0]           anchor_z,
  // results
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic signed [scv_pkg::OUT_W-1:0] out_x,
  output logic signed [scv_pkg::OUT_W-1:0] out_y,
  output logic signed [scv_pkg::OUT_W-1:0] out_z,
  output logic                         saturated
);

  localparam int AW    = $clog2(MAX_ANCHORS);
  localparam int CB    = COORD_BITS;
  localparam int STAGES = 19;

  // configuration registers
  logic signed [31:0] q_start;
  logic [31:0]        q_scale;
  logic [4:0]         anchor_count;
  logic [1:0]         reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];

  always_ff @(posedge clk) begin
    if (rst) begin
      q_start      <= '0;
      q_scale      <= scv_pkg::Q_SCALE_RST;
      anchor_count <= scv_pkg::ANCHOR_COUNT_RST;
    end else if (psel && penable && pwrite) begin
      unique case (reg_idx)
        scv_pkg::REG_Q_START:      q_start      <= pwdata;
        scv_pkg::REG_Q_SCALE:      q_scale      <= pwdata;
        scv_pkg::REG_ANCHOR_COUNT: anchor_count <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      scv_pkg::REG_Q_START:      prdata = q_start;
      scv_pkg::REG_Q_SCALE:      prdata = q_scale;
      scv_pkg::REG_ANCHOR_COUNT: prdata = 32'(anchor_count);
      default:                   prdata = '0;
    endcase
  end

  // pipeline control: valid and mode shift line
  logic             vld [STAGES];
  logic             mde [STAGES];
  logic             en;

  assign en        = !(vld[STAGES-1] && mde[STAGES-1]) || out_ready;
  assign in_ready  = en;
  assign out_valid = vld[STAGES-1] && mde[STAGES-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < STAGES; i++) begin
        vld[i] <= 1'b0;
      end
    end else if (en) begin
      vld[0] <= in_valid;
      for (int i = 1; i < STAGES; i++) begin
        vld[i] <= vld[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      mde[0] <= mode;
      for (int i = 1; i < STAGES; i++) begin
        mde[i] <= mde[i-1];
      end
    end
  end

  // stage 1: input transfer
  logic [1:0]         ord_1, ord_2, ord_3, ord_4, ord_5;
  logic signed [31:0] pos_1;
  logic [3:0]         slot_1, slot_2, slot_3, slot_4;
  logic [3*CB-1:0]    wdat_1, wdat_2, wdat_3, wdat_4;

  always_ff @(posedge clk) begin
    if (en) begin
      ord_1  <= deriv_order;
      pos_1  <= sample_position;
      slot_1 <= anchor_slot;
      wdat_1 <= {CB'(64'(unsigned'(anchor_z))), CB'(64'(unsigned'(anchor_y))),
                 CB'(64'(unsigned'(anchor_x)))};
    end
  end

  // stage 2: offset from range start
  logic signed [32:0] diff_2;

  always_ff @(posedge clk) begin
    if (en) begin
      diff_2 <= 33'(pos_1) - 33'(q_start);
      ord_2  <= ord_1;
      slot_2 <= slot_1;
      wdat_2 <= wdat_1;
    end
  end

  // stage 3: scale to segments
  logic [63:0] p_3;
  logic        dneg_3;

  always_ff @(posedge clk) begin
    if (en) begin
      p_3    <= diff_2[31:0] * q_scale;
      dneg_3 <= diff_2[32];
      ord_3  <= ord_2;
      slot_3 <= slot_2;
      wdat_3 <= wdat_2;
    end
  end

  // stage 4: segment and fraction with clamping at both ends
  logic [31:0]           n_use, seg_big;
  logic [AW-1:0]         seg_next, seg_4;
  logic [scv_pkg::T_W-1:0] t_next, t_4;

  always_comb begin
    n_use = 32'(anchor_count);
    if (n_use < 32'd2) begin
      n_use = 32'd2;
    end else if (n_use > 32'(MAX_ANCHORS)) begin
      n_use = 32'(MAX_ANCHORS);
    end
    if (dneg_3) begin
      seg_big = '0;
      t_next  = '0;
    end else begin
      seg_big = p_3[63:32];
      t_next  = scv_pkg::T_W'(p_3[31:2]);
    end
    if (seg_big >= n_use - 32'd1) begin
      seg_next = AW'(n_use - 32'd2);
      t_next   = scv_pkg::ONE_Q30;
    end else begin
      seg_next = AW'(seg_big);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      seg_4  <= seg_next;
      t_4    <= t_next;
      ord_4  <= ord_3;
      slot_4 <= slot_3;
      wdat_4 <= wdat_3;
    end
  end

  // stage 5: anchor table access, writes and reads in item order
  logic            mem_we;
  logic [3*CB-1:0] rd_a, rd_b;

  assign mem_we = en && vld[3] && (mde[3] == scv_pkg::MODE_WRITE)
                && (32'(slot_4) < 32'(MAX_ANCHORS));

  scv_anchor_mem #(
    .DEPTH  (MAX_ANCHORS),
    .WORD_W (3 * CB)
  ) u_mem (
    .clk     (clk),
    .en      (en),
    .we      (mem_we),
    .waddr   (AW'(slot_4)),
    .wdata   (wdat_4),
    .raddr_a (seg_4),
    .raddr_b (seg_4 + AW'(1)),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      ord_5 <= ord_4;
    end
  end

  // stages 5 to 9: blend weight
  logic signed [scv_pkg::W_W-1:0] w_9;

  scv_weight u_weight (
    .clk (clk),
    .en  (en),
    .t   (t_4),
    .ord (ord_4),
    .w   (w_9)
  );

  // stages 6 to 19: one lane per coordinate
  logic sat_x, sat_y, sat_z;

  scv_lane #(.COORD_BITS(CB)) u_lane_x (
    .clk     (clk),
    .en      (en),
    .a0      (rd_a[CB-1:0]),
    .a1      (rd_b[CB-1:0]),
    .ord     (ord_5),
    .w       (w_9),
    .q_scale (q_scale),
    .res     (out_x),
    .sat     (sat_x)
  );

  scv_lane #(.COORD_BITS(CB)) u_lane_y (
    .clk     (clk),
    .en      (en),
    .a0      (rd_a[2*CB-1:CB]),
    .a1      (rd_b[2*CB-1:CB]),
    .ord     (ord_5),
    .w       (w_9),
    .q_scale (q_scale),
    .res     (out_y),
    .sat     (sat_y)
  );

  scv_lane #(.COORD_BITS(CB)) u_lane_z (
    .clk     (clk),
    .en      (en),
    .a0      (rd_a[3*CB-1:2*CB]),
    .a1      (rd_b[3*CB-1:2*CB]),
    .ord     (ord_5),
    .w       (w_9),
    .q_scale (q_scale),
    .res     (out_z),
    .sat     (sat_z)
  );

  assign saturated = sat_x || sat_y || sat_z;

endmodule
